>>> design/dss_pkg.sv
// Shared types and constants for the dual stack shared store.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

   // Field widths
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned SIZE_W   = 9;

   // Default store depth in words
   localparam int unsigned DEPTH_DEFAULT = 256;

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PEEK = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Stack selects
   localparam logic SEL_A = 1'b0;
   localparam logic SEL_B = 1'b1;

   // Value returned when no element is read
   localparam logic signed [DATA_W-1:0] NEG_ONE = '1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_item;  // capture the request beat
      logic exec;       // decide, access the store, update the counters
      logic load_out;   // move the result into the response register
   } cmd_type;

endpackage

`default_nettype wire

>>> design/dss_req_if.sv
// Request channel of the dual stack shared store: valid/ready plus one operation.
// Depends on dss_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dss_req_if;
   logic                                valid;
   logic                                ready;
   logic [dss_pkg::OPCODE_W-1:0]        opcode;
   logic                                stack_sel;
   logic signed [dss_pkg::DATA_W-1:0]   push_value;

   modport source (output valid, opcode, stack_sel, push_value, input ready);
   modport sink   (input valid, opcode, stack_sel, push_value, output ready);
endinterface

`default_nettype wire

>>> design/dss_rsp_if.sv
// Response channel of the dual stack shared store: valid/ready plus one result.
// Depends on dss_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dss_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dss_pkg::DATA_W-1:0]   read_value;
   logic [dss_pkg::STATUS_W-1:0]        status;
   logic [dss_pkg::SIZE_W-1:0]          size_a;
   logic [dss_pkg::SIZE_W-1:0]          size_b;

   modport source (output valid, read_value, status, size_a, size_b, input ready);
   modport sink   (input valid, read_value, status, size_a, size_b, output ready);
endinterface

`default_nettype wire

>>> design/dss_ctrl.sv
// Sequencing controller: accepts a request beat, steps it through the datapath
// and owns the response valid flag. Depends on dss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dss_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dss_pkg::cmd_type      cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Response register can take a result when empty or draining this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.load_item = 1'b0;
      cmd.exec      = 1'b0;
      cmd.load_out  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the response register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid: set on load, drop on a taken beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> design/dss_datapath.sv
// Datapath: request registers, the shared store, both stack counters and the
// response register. Driven by dss_ctrl commands; depends on dss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dss_datapath #(
   parameter int unsigned DEPTH = dss_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire dss_pkg::cmd_type                    cmd,
   input  wire logic [dss_pkg::OPCODE_W-1:0]        req_opcode,
   input  wire logic                                req_stack_sel,
   input  wire logic signed [dss_pkg::DATA_W-1:0]   req_push_value,
   output logic signed [dss_pkg::DATA_W-1:0]        rsp_read_value,
   output logic [dss_pkg::STATUS_W-1:0]             rsp_status,
   output logic [dss_pkg::SIZE_W-1:0]               rsp_size_a,
   output logic [dss_pkg::SIZE_W-1:0]               rsp_size_b
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned EW = CW + dss_pkg::SIZE_W;
   localparam logic [AW-1:0] LAST   = AW'(DEPTH - 1);
   localparam logic [CW:0]   DEPTHV = (CW + 1)'(DEPTH);

   // Store
   logic signed [dss_pkg::DATA_W-1:0] mem [DEPTH];

   // Captured request
   logic [dss_pkg::OPCODE_W-1:0]      op_ff;
   logic                              sel_ff;
   logic signed [dss_pkg::DATA_W-1:0] val_ff;

   // Counters
   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;

   // Execute results
   logic                              use_mem_ff;
   logic [dss_pkg::STATUS_W-1:0]      st_ff, st_in;
   logic signed [dss_pkg::DATA_W-1:0] rd_data_ff;

   // Response register
   logic signed [dss_pkg::DATA_W-1:0] read_value_ff;
   logic [dss_pkg::STATUS_W-1:0]      status_ff;
   logic [dss_pkg::SIZE_W-1:0]        size_a_ff, size_b_ff;

   logic [CW:0]   sum;
   logic [CW-1:0] cnt_sel, ca_m1, cb_m1;
   logic          full, empty, is_push, is_pop, is_read, push_ok, rd_ok;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] ext_a, ext_b;

   // Decode and full/empty tests
   assign sum     = {1'b0, count_a_ff} + {1'b0, count_b_ff};
   assign full    = (sum >= DEPTHV);
   assign cnt_sel = (sel_ff == dss_pkg::SEL_B) ? count_b_ff : count_a_ff;
   assign empty   = (cnt_sel == '0);
   assign is_push = (op_ff == dss_pkg::OP_PUSH);
   assign is_pop  = (op_ff == dss_pkg::OP_POP);
   assign is_read = is_pop || (op_ff == dss_pkg::OP_PEEK);
   assign push_ok = is_push && !full;
   assign rd_ok   = is_read && !empty;

   // Addresses: A grows up from entry 0, B grows down from the last entry
   assign ca_m1   = count_a_ff - CW'(1);
   assign cb_m1   = count_b_ff - CW'(1);
   assign wr_addr = (sel_ff == dss_pkg::SEL_B) ? (LAST - count_b_ff[AW-1:0])
                                               : count_a_ff[AW-1:0];
   assign rd_addr = (sel_ff == dss_pkg::SEL_B) ? (LAST - cb_m1[AW-1:0])
                                               : ca_m1[AW-1:0];

   // Status of this operation
   always_comb begin
      priority if (is_push && full) begin
         st_in = dss_pkg::ST_FULL;
      end else if (is_read && empty) begin
         st_in = dss_pkg::ST_EMPTY;
      end else begin
         st_in = dss_pkg::ST_OK;
      end
   end

   // Counter updates
   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      if (cmd.exec) begin
         if (push_ok) begin
            if (sel_ff == dss_pkg::SEL_B) begin
               count_b_in = count_b_ff + CW'(1);
            end else begin
               count_a_in = count_a_ff + CW'(1);
            end
         end else if (rd_ok && is_pop) begin
            if (sel_ff == dss_pkg::SEL_B) begin
               count_b_in = cb_m1;
            end else begin
               count_a_in = ca_m1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= req_opcode;
         sel_ff <= req_stack_sel;
         val_ff <= req_push_value;
      end
   end

   // Store access: one write or one registered read per operation
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (push_ok) begin
            mem[wr_addr] <= val_ff;
         end
         rd_data_ff <= mem[rd_addr];
         use_mem_ff <= rd_ok;
         st_ff      <= st_in;
      end
   end

   // Response register; sizes carry the low bits of the counters
   assign ext_a = EW'(count_a_ff);
   assign ext_b = EW'(count_b_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         read_value_ff <= use_mem_ff ? rd_data_ff : dss_pkg::NEG_ONE;
         status_ff     <= st_ff;
         size_a_ff     <= ext_a[dss_pkg::SIZE_W-1:0];
         size_b_ff     <= ext_b[dss_pkg::SIZE_W-1:0];
      end
   end

   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_size_a     = size_a_ff;
   assign rsp_size_b     = size_b_ff;

endmodule

`default_nettype wire

>>> design/dual_stack_shared_store.sv
// Two stacks in one store: A grows up from entry 0, B down from entry DEPTH-1.
// An accepted request beat passes through capture, store access with registered read and
// the response register load before the response beat is valid.
// A new request is taken only once the last result is loaded; a waiting response
// stalls the next operation at its last step.
// Reset clears both counters and the control state; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module dual_stack_shared_store #(
   parameter int unsigned DEPTH = dss_pkg::DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dss_req_if.sink    req_chan,
   dss_rsp_if.source  rsp_chan
);

   dss_pkg::cmd_type cmd;
   logic             req_ready;
   logic             rsp_valid;

   dss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   dss_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_chan.opcode),
      .req_stack_sel  (req_chan.stack_sel),
      .req_push_value (req_chan.push_value),
      .rsp_read_value (rsp_chan.read_value),
      .rsp_status     (rsp_chan.status),
      .rsp_size_a     (rsp_chan.size_a),
      .rsp_size_b     (rsp_chan.size_b)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // One operation in flight: ready drops after an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while an operation is in flight");

   // A response appears only through a response register load
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.load_out))
      else $error("response valid without a result load");

   // Refused or empty operations read nothing
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == dss_pkg::ST_FULL ||
                          rsp_chan.status == dss_pkg::ST_EMPTY))
      |-> (rsp_chan.read_value == dss_pkg::NEG_ONE))
      else $error("refused or empty result carries a read value");

endmodule

`default_nettype wire

>>> tb/dual_stack_shared_store_tb.sv
// Testbench for the dual stack shared store: directed and random push, pop and peek traffic.
// A clocked driver and monitor run on the request and response interfaces.
// A shadow pair of stacks predicts every response. Depends on dss_pkg, dss_req_if and dss_rsp_if.
`timescale 1ns / 1ps

module dual_stack_shared_store_tb;

   localparam int unsigned DEPTH         = dss_pkg::DEPTH_DEFAULT;
   localparam int unsigned CLK_HALF      = 6;
   localparam int unsigned RESET_CYCLES  = 12;
   localparam int unsigned DRAIN_CYCLES  = 10;
   localparam int unsigned HOLD_AT_BEAT  = 300;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned TIMEOUT_CYCLES = 200000;

   // Opcode with no operation behind it
   localparam logic [dss_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef enum {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_type;

   typedef struct {
      logic [dss_pkg::OPCODE_W-1:0]      opcode;
      logic                              stack_sel;
      logic signed [dss_pkg::DATA_W-1:0] push_value;
      int unsigned                       gap;
      bit                                wait_idle;
   } stack_op_type;

   typedef struct packed {
      logic signed [dss_pkg::DATA_W-1:0] read_value;
      logic [dss_pkg::STATUS_W-1:0]      status;
      logic [dss_pkg::SIZE_W-1:0]        size_a;
      logic [dss_pkg::SIZE_W-1:0]        size_b;
   } stack_answer_type;

   logic clock;
   logic reset;

   dss_req_if req_chan ();
   dss_rsp_if rsp_chan ();

   dual_stack_shared_store #(.DEPTH(DEPTH)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow stacks
   logic [dss_pkg::DATA_W-1:0] shadow_store [DEPTH];
   int unsigned                shadow_count_a;
   int unsigned                shadow_count_b;

   stack_op_type     pending_ops[$];
   stack_answer_type expected_answers[$];
   int unsigned      mismatches;

   // Driver state
   bit           drv_offer;
   bit           drv_staged;
   int unsigned  drv_gap;
   stack_op_type drv_next;
   stack_op_type drv_current;

   // Monitor state
   int unsigned      stall_left;
   int unsigned      rsp_seen;
   stack_answer_type want;

   // Apply one operation to the shadow stacks and return the response it gives
   function automatic stack_answer_type predict_answer(stack_op_type op);
      stack_answer_type ans;
      int unsigned      held;
      ans.read_value = dss_pkg::NEG_ONE;
      ans.status     = dss_pkg::ST_OK;
      case (op.opcode)
         dss_pkg::OP_PUSH: begin
            if (shadow_count_a + shadow_count_b >= DEPTH) begin
               ans.status = dss_pkg::ST_FULL;
            end else if (op.stack_sel == dss_pkg::SEL_A) begin
               shadow_store[shadow_count_a] = op.push_value;
               shadow_count_a++;
            end else begin
               shadow_store[DEPTH - 1 - shadow_count_b] = op.push_value;
               shadow_count_b++;
            end
         end
         dss_pkg::OP_POP, dss_pkg::OP_PEEK: begin
            held = (op.stack_sel == dss_pkg::SEL_A) ? shadow_count_a : shadow_count_b;
            if (held == 0) begin
               ans.status = dss_pkg::ST_EMPTY;
            end else begin
               if (op.stack_sel == dss_pkg::SEL_A) begin
                  ans.read_value = shadow_store[shadow_count_a - 1];
                  if (op.opcode == dss_pkg::OP_POP) shadow_count_a--;
               end else begin
                  ans.read_value = shadow_store[DEPTH - shadow_count_b];
                  if (op.opcode == dss_pkg::OP_POP) shadow_count_b--;
               end
            end
         end
         default: ;
      endcase
      ans.size_a = shadow_count_a[dss_pkg::SIZE_W-1:0];
      ans.size_b = shadow_count_b[dss_pkg::SIZE_W-1:0];
      return ans;
   endfunction

   task automatic queue_op(input logic [dss_pkg::OPCODE_W-1:0] opcode, input logic sel,
                           input logic [dss_pkg::DATA_W-1:0] value, input bit wait_idle);
      stack_op_type op;
      op.opcode     = opcode;
      op.stack_sel  = sel;
      op.push_value = value;
      op.gap        = $urandom_range(0, 4);
      op.wait_idle  = wait_idle;
      pending_ops.push_back(op);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // Drive the request channel: retire accepted beats, then count the gap and offer the next
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         drv_staged = 1'b0;
         drv_gap    = 0;
      end else begin
         drv_offer = req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            expected_answers.push_back(predict_answer(drv_current));
            drv_offer = 1'b0;
         end
         if (!drv_offer && !drv_staged && pending_ops.size() != 0) begin
            drv_next   = pending_ops.pop_front();
            drv_staged = 1'b1;
            drv_gap    = drv_next.gap;
         end
         if (!drv_offer && drv_staged) begin
            if (drv_gap > 0) begin
               drv_gap--;
            end else if (!drv_next.wait_idle || expected_answers.size() == 0) begin
               drv_offer   = 1'b1;
               drv_staged  = 1'b0;
               drv_current = drv_next;
               req_chan.opcode     <= drv_next.opcode;
               req_chan.stack_sel  <= drv_next.stack_sel;
               req_chan.push_value <= drv_next.push_value;
            end
         end
         req_chan.valid <= drv_offer;
      end
   end

   // Take response beats, compare with the oldest prediction, draw the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
         rsp_seen   = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_answers.size() == 0) begin
               $error("response beat with no prediction pending");
               mismatches++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_chan.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value,
                         rsp_chan.read_value);
                  mismatches++;
               end
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  mismatches++;
               end
               if (rsp_chan.size_a !== want.size_a) begin
                  $error("size_a: expected %0d, got %0d", want.size_a, rsp_chan.size_a);
                  mismatches++;
               end
               if (rsp_chan.size_b !== want.size_b) begin
                  $error("size_b: expected %0d, got %0d", want.size_b, rsp_chan.size_b);
                  mismatches++;
               end
            end
            rsp_seen++;
            // every third stretch of 64 beats runs without stalls
            if ((rsp_seen / 64) % 3 == 2) stall_left = 0;
            else stall_left = $urandom_range(0, 4);
            // hold off once for a long time so the block backs up
            if (rsp_seen == HOLD_AT_BEAT) stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      traffic_mode_type                 mode;
      int unsigned                      pct_a;
      int unsigned                      seg_len;
      int unsigned                      roll;
      logic [dss_pkg::OPCODE_W-1:0]     opcode;
      logic                             sel;

      mismatches          = 0;
      shadow_count_a      = 0;
      shadow_count_b      = 0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = dss_pkg::OP_PUSH;
      req_chan.stack_sel  = dss_pkg::SEL_A;
      req_chan.push_value = '0;
      rsp_chan.ready      = 1'b0;

      // Directed: empty stacks, unused opcode, extreme values, every operation
      queue_op(dss_pkg::OP_PEEK, dss_pkg::SEL_A, $urandom, 1'b0);
      queue_op(dss_pkg::OP_POP,  dss_pkg::SEL_A, $urandom, 1'b0);
      queue_op(dss_pkg::OP_PEEK, dss_pkg::SEL_B, $urandom, 1'b0);
      queue_op(dss_pkg::OP_POP,  dss_pkg::SEL_B, $urandom, 1'b0);
      queue_op(OP_UNUSED,        dss_pkg::SEL_A, 32'hFFFF_FFFF, 1'b0);
      queue_op(OP_UNUSED,        dss_pkg::SEL_B, 32'h0000_0000, 1'b0);
      queue_op(dss_pkg::OP_PUSH, dss_pkg::SEL_A, 32'h7FFF_FFFF, 1'b0);
      queue_op(dss_pkg::OP_PUSH, dss_pkg::SEL_A, 32'h8000_0000, 1'b0);
      queue_op(dss_pkg::OP_PUSH, dss_pkg::SEL_B, 32'h0000_0000, 1'b0);
      queue_op(dss_pkg::OP_PUSH, dss_pkg::SEL_B, 32'hFFFF_FFFF, 1'b0);
      queue_op(dss_pkg::OP_PUSH, dss_pkg::SEL_B, 32'h5555_5555, 1'b0);
      queue_op(OP_UNUSED,        dss_pkg::SEL_A, $urandom, 1'b0);
      queue_op(dss_pkg::OP_PEEK, dss_pkg::SEL_A, $urandom, 1'b0);
      queue_op(dss_pkg::OP_POP,  dss_pkg::SEL_A, $urandom, 1'b0);
      queue_op(dss_pkg::OP_PEEK, dss_pkg::SEL_B, $urandom, 1'b0);
      queue_op(dss_pkg::OP_POP,  dss_pkg::SEL_B, $urandom, 1'b0);
      queue_op(dss_pkg::OP_POP,  dss_pkg::SEL_B, $urandom, 1'b0);
      queue_op(dss_pkg::OP_POP,  dss_pkg::SEL_B, $urandom, 1'b0);
      queue_op(dss_pkg::OP_POP,  dss_pkg::SEL_A, $urandom, 1'b0);
      queue_op(dss_pkg::OP_POP,  dss_pkg::SEL_A, $urandom, 1'b0);
      queue_op(dss_pkg::OP_PUSH, dss_pkg::SEL_A, 32'hAAAA_AAAA, 1'b0);
      queue_op(dss_pkg::OP_PEEK, dss_pkg::SEL_A, $urandom, 1'b0);
      queue_op(dss_pkg::OP_POP,  dss_pkg::SEL_A, $urandom, 1'b0);

      // Random: fill A to the full store, churn, drain, fill B to the full store, then churn again
      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0:       begin mode = MODE_FILL;  pct_a = 100; seg_len = 150; end
            1:       begin mode = MODE_FILL;  pct_a = 100; seg_len = 150; end
            2:       begin mode = MODE_MIXED; pct_a = 50;  seg_len = 100; end
            3:       begin mode = MODE_DRAIN; pct_a = 100; seg_len = 250; end
            4:       begin mode = MODE_FILL;  pct_a = 0;   seg_len = 300; end
            default: begin mode = MODE_MIXED; pct_a = 50;  seg_len = 50;  end
         endcase
         for (int k = 0; k < seg_len; k++) begin
            roll = $urandom_range(0, 99);
            case (mode)
               MODE_FILL:
                  opcode = (roll < 90) ? dss_pkg::OP_PUSH :
                           (roll < 94) ? dss_pkg::OP_POP :
                           (roll < 98) ? dss_pkg::OP_PEEK : OP_UNUSED;
               MODE_MIXED:
                  opcode = (roll < 45) ? dss_pkg::OP_PUSH :
                           (roll < 70) ? dss_pkg::OP_POP :
                           (roll < 97) ? dss_pkg::OP_PEEK : OP_UNUSED;
               default:
                  opcode = (roll < 8)  ? dss_pkg::OP_PUSH :
                           (roll < 80) ? dss_pkg::OP_POP :
                           (roll < 97) ? dss_pkg::OP_PEEK : OP_UNUSED;
            endcase
            sel = ($urandom_range(0, 99) < pct_a) ? dss_pkg::SEL_A : dss_pkg::SEL_B;
            // first beat of a segment waits for the block to go idle
            queue_op(opcode, sel, $urandom, k == 0);
            // runs of back-to-back beats
            if (k % 80 < 20) pending_ops[pending_ops.size() - 1].gap = 0;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to be sent and answered, then let the pipeline settle
      while (pending_ops.size() != 0 || drv_staged || drv_offer || req_chan.valid ||
             expected_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("dual_stack_shared_store_tb passed");
      end else begin
         $display("dual_stack_shared_store_tb failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_CYCLES * 2 * CLK_HALF);
      $display("dual_stack_shared_store_tb failed");
      $finish;
   end

endmodule
